/* sv/sgb_pkg.sv */
// Shared types, constants and arithmetic helpers of the separable blur unit.
`default_nettype none
package sgb_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int COL_BITS     = 10;
  localparam int ROW_BITS     = 16;
  localparam int DATA_BITS    = 16;
  localparam int TAP_BITS     = 16;
  localparam int MAX_RADIUS   = 3;
  localparam int WIN_DEPTH    = 2 * MAX_RADIUS + 1;
  localparam int LANE_BITS    = 3;
  localparam int PROD_BITS    = DATA_BITS + TAP_BITS;
  localparam int ACC_BITS     = PROD_BITS + 3;
  localparam int Q_DEPTH      = 4;
  localparam int Q_PTR_BITS   = 2;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DAT_BITS = 16;
  localparam int WREG_BITS    = 11;
  localparam int RAD_BITS     = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_RADIUS = 3'd2,
    REG_TAP0   = 3'd3,
    REG_TAP1   = 3'd4,
    REG_TAP2   = 3'd5,
    REG_TAP3   = 3'd6
  } reg_idx_t;

  typedef logic [WIN_DEPTH-1:0][DATA_BITS-1:0] lanes_t;
  typedef logic [WIN_DEPTH-1:0][PROD_BITS-1:0] prods_t;
  typedef logic [MAX_RADIUS:0][TAP_BITS-1:0]   taps_t;

  typedef struct packed {
    logic [WREG_BITS-1:0] width;
    logic [ROW_BITS-1:0]  height;
    logic [RAD_BITS-1:0]  radius;
    taps_t                taps;
  } cfg_t;

  // one horizontal result to be formed: operands already gathered per lane
  typedef struct packed {
    lanes_t              hop;
    logic [COL_BITS-1:0] x;
    logic [ROW_BITS-1:0] row;
    logic [2:0]          rmod;
    logic                last_row;
    logic                last_job;
  } hjob_t;

  function automatic logic [COL_BITS-1:0] eff_wm1(input cfg_t c);
    logic [WREG_BITS-1:0] t;
    if (c.width == '0) t = '0;
    else if (c.width > WREG_BITS'(MAX_WIDTH)) t = WREG_BITS'(MAX_WIDTH - 1);
    else t = c.width - WREG_BITS'(1);
    return t[COL_BITS-1:0];
  endfunction

  function automatic logic [ROW_BITS-1:0] eff_hm1(input cfg_t c);
    return (c.height == '0) ? '0 : c.height - ROW_BITS'(1);
  endfunction

  // tap of lane k (distance |k-MAX_RADIUS|), zero outside the radius
  function automatic logic [TAP_BITS-1:0] lane_tap(input logic [LANE_BITS-1:0] k,
                                                   input cfg_t c);
    logic [LANE_BITS-1:0] d;
    d = (k >= LANE_BITS'(MAX_RADIUS)) ? k - LANE_BITS'(MAX_RADIUS)
                                      : LANE_BITS'(MAX_RADIUS) - k;
    if (d > LANE_BITS'(c.radius)) return '0;
    return c.taps[d[RAD_BITS-1:0]];
  endfunction

  function automatic logic [DATA_BITS-1:0] finish(input logic [ACC_BITS-1:0] acc);
    logic [ACC_BITS-1:0]          rnd;
    logic [ACC_BITS-TAP_BITS-1:0] q;
    rnd = acc + (ACC_BITS'(1) << (TAP_BITS - 1));
    q   = rnd[ACC_BITS-1:TAP_BITS];
    return (|q[ACC_BITS-TAP_BITS-1:DATA_BITS]) ? '1 : q[DATA_BITS-1:0];
  endfunction

  function automatic logic [ACC_BITS-1:0] sum_prods(input prods_t p);
    logic [ACC_BITS-1:0] s;
    s = '0;
    for (int k = 0; k < WIN_DEPTH; k++) s = s + ACC_BITS'(p[k]);
    return s;
  endfunction

endpackage
`default_nettype wire

/* sv/sgb_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none
module sgb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    if (re) rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* sv/sgb_queue.sv */
// Short job queue between the front end and the filter back end.
`default_nettype none
module sgb_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire sgb_pkg::hjob_t push_job,
  output logic                full,
  input  wire logic           pop,
  output sgb_pkg::hjob_t      head,
  output logic                empty
);

  sgb_pkg::hjob_t                  mem_r [sgb_pkg::Q_DEPTH];
  logic [sgb_pkg::Q_PTR_BITS-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [sgb_pkg::Q_PTR_BITS-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [sgb_pkg::Q_PTR_BITS:0]    cnt_r, cnt_nxt;

  assign full  = (cnt_r == (sgb_pkg::Q_PTR_BITS+1)'(sgb_pkg::Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + (sgb_pkg::Q_PTR_BITS)'(push);
    rd_ptr_nxt = rd_ptr_r + (sgb_pkg::Q_PTR_BITS)'(pop);
    cnt_nxt    = cnt_r + (sgb_pkg::Q_PTR_BITS+1)'(push) - (sgb_pkg::Q_PTR_BITS+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/sgb_front.sv */
// Front end: sample window, raster counters and horizontal job issue.
`default_nettype none
module sgb_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire sgb_pkg::cfg_t                   cfg,
  input  wire logic                            restart,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [sgb_pkg::DATA_BITS-1:0]   in_sample,
  output logic                                 q_push,
  output sgb_pkg::hjob_t                       q_job,
  input  wire logic                            q_full
);

  localparam int CB = sgb_pkg::COL_BITS;
  localparam int RB = sgb_pkg::ROW_BITS;

  sgb_pkg::lanes_t win_r, win_nxt;
  logic [CB-1:0]   col_r, col_nxt;
  logic [RB-1:0]   row_r, row_nxt;
  logic [2:0]      rmod_r, rmod_nxt;
  logic            g_valid_r, g_valid_nxt;
  logic [CB-1:0]   g_x_r, g_x_nxt;
  logic [CB-1:0]   g_hi_r, g_hi_nxt;
  logic [CB-1:0]   g_c_r, g_c_nxt;
  logic [RB-1:0]   g_row_r, g_row_nxt;
  logic [2:0]      g_rmod_r, g_rmod_nxt;
  logic            g_last_row_r, g_last_row_nxt;

  logic [CB-1:0] wm1;
  logic [RB-1:0] hm1;
  logic [CB-1:0] rad;
  logic          g_done, accept, row_end, has_job, last_row;
  logic [CB-1:0] lo;

  assign wm1      = sgb_pkg::eff_wm1(cfg);
  assign hm1      = sgb_pkg::eff_hm1(cfg);
  assign rad      = CB'(cfg.radius);
  assign q_push   = g_valid_r && !q_full;
  assign g_done   = q_push && (g_x_r == g_hi_r);
  assign in_stall = g_valid_r && !g_done;
  assign accept   = in_valid && !in_stall;
  assign row_end  = (col_r >= wm1);
  assign last_row = (row_r >= hm1);
  assign has_job  = row_end || (col_r >= rad);
  assign lo       = (col_r >= rad) ? col_r - rad : '0;

  // gather the horizontal operands of the job under issue, clamping at row edges
  always_comb begin
    logic signed [CB+1:0] xs;
    logic signed [CB+1:0] dd;
    logic signed [CB+1:0] xc;
    logic [sgb_pkg::LANE_BITS-1:0] lane_d;
    q_job.x        = g_x_r;
    q_job.row      = g_row_r;
    q_job.rmod     = g_rmod_r;
    q_job.last_row = g_last_row_r;
    q_job.last_job = (g_x_r == g_hi_r);
    for (int k = 0; k < sgb_pkg::WIN_DEPTH; k++) begin
      xs = $signed({2'b00, g_x_r}) + $signed((CB+2)'(k)) -
           $signed((CB+2)'(sgb_pkg::MAX_RADIUS));
      if (xs < 0) xc = '0;
      else if (xs > $signed({2'b00, wm1})) xc = $signed({2'b00, wm1});
      else xc = xs;
      dd     = $signed({2'b00, g_c_r}) - xc;
      lane_d = (k >= sgb_pkg::MAX_RADIUS) ? (sgb_pkg::LANE_BITS)'(k - sgb_pkg::MAX_RADIUS)
                                          : (sgb_pkg::LANE_BITS)'(sgb_pkg::MAX_RADIUS - k);
      if (lane_d <= (sgb_pkg::LANE_BITS)'(cfg.radius) && dd >= 0 &&
          dd < $signed((CB+2)'(sgb_pkg::WIN_DEPTH)))
        q_job.hop[k] = win_r[dd[sgb_pkg::LANE_BITS-1:0]];
      else
        q_job.hop[k] = '0;
    end
  end

  always_comb begin
    win_nxt        = win_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    rmod_nxt       = rmod_r;
    g_valid_nxt    = g_valid_r;
    g_x_nxt        = g_x_r;
    g_hi_nxt       = g_hi_r;
    g_c_nxt        = g_c_r;
    g_row_nxt      = g_row_r;
    g_rmod_nxt     = g_rmod_r;
    g_last_row_nxt = g_last_row_r;
    if (g_done) g_valid_nxt = 1'b0;
    else if (q_push) g_x_nxt = g_x_r + CB'(1);
    if (accept) begin
      win_nxt[0] = in_sample;
      for (int i = 1; i < sgb_pkg::WIN_DEPTH; i++) win_nxt[i] = win_r[i-1];
      g_valid_nxt    = has_job;
      g_x_nxt        = lo;
      g_hi_nxt       = row_end ? col_r : lo;
      g_c_nxt        = col_r;
      g_row_nxt      = row_r;
      g_rmod_nxt     = rmod_r;
      g_last_row_nxt = last_row;
      if (row_end) begin
        col_nxt = '0;
        if (last_row) begin
          row_nxt  = '0;
          rmod_nxt = '0;
        end else begin
          row_nxt  = row_r + RB'(1);
          rmod_nxt = (rmod_r == 3'd6) ? 3'd0 : rmod_r + 3'd1;
        end
      end else begin
        col_nxt = col_r + CB'(1);
      end
    end
    if (restart) begin
      col_nxt  = '0;
      row_nxt  = '0;
      rmod_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    win_r        <= win_nxt;
    g_x_r        <= g_x_nxt;
    g_hi_r       <= g_hi_nxt;
    g_c_r        <= g_c_nxt;
    g_row_r      <= g_row_nxt;
    g_rmod_r     <= g_rmod_nxt;
    g_last_row_r <= g_last_row_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      rmod_r    <= '0;
      g_valid_r <= 1'b0;
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      rmod_r    <= rmod_nxt;
      g_valid_r <= g_valid_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/sgb_back.sv */
// Back end: horizontal MAC, line store, vertical MAC and output register.
`default_nettype none
module sgb_back (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire sgb_pkg::cfg_t                  cfg,
  input  wire logic                           q_empty,
  input  wire sgb_pkg::hjob_t                 q_head,
  output logic                                q_pop,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [sgb_pkg::DATA_BITS-1:0]       out_value,
  output logic [sgb_pkg::COL_BITS-1:0]        out_x,
  output logic [sgb_pkg::ROW_BITS-1:0]        out_y,
  output logic                                out_last_of_run
);

  localparam int CB = sgb_pkg::COL_BITS;
  localparam int RB = sgb_pkg::ROW_BITS;
  localparam int DB = sgb_pkg::DATA_BITS;
  localparam int WD = sgb_pkg::WIN_DEPTH;
  localparam int LB = sgb_pkg::LANE_BITS;

  // P: horizontal products
  logic                 p_valid_r, p_valid_nxt;
  sgb_pkg::prods_t      p_prod_r;
  logic [DB-1:0]        p_center_r;
  logic [CB-1:0]        p_x_r;
  logic [RB-1:0]        p_row_r;
  logic [2:0]           p_rmod_r;
  logic                 p_last_row_r, p_last_job_r;
  logic [WD-1:0]        p_patch_r, p_patch_nxt;
  sgb_pkg::lanes_t      p_pval_r, p_pval_nxt;

  // V: horizontal result plus the column, walked row by row
  logic                 v_valid_r, v_valid_nxt;
  logic [DB-1:0]        v_hval_r;
  sgb_pkg::lanes_t      v_col_r;
  logic [CB-1:0]        v_x_r;
  logic [RB-1:0]        v_row_r;
  logic [2:0]           v_rmod_r;
  logic                 v_last_job_r, v_has_y_r;
  logic [RB-1:0]        v_y_r, v_y_nxt;
  logic [RB-1:0]        v_yend_r;

  // M: vertical products
  logic                 m_valid_r, m_valid_nxt;
  sgb_pkg::prods_t      m_prod_r;
  logic [DB-1:0]        m_center_r;
  logic [CB-1:0]        m_x_r;
  logic [RB-1:0]        m_y_r;
  logic                 m_last_r;

  // O: output register
  logic                 o_valid_r, o_valid_nxt;
  logic [DB-1:0]        o_value_r;
  logic [CB-1:0]        o_x_r;
  logic [RB-1:0]        o_y_r;
  logic                 o_last_r;

  logic [RB-1:0]        hm1;
  logic [WD-1:0][sgb_pkg::TAP_BITS-1:0] lane_taps;
  logic [WD-1:0]        bank_we, hit_head, hit_p;
  sgb_pkg::lanes_t      ram_q, col_in, vop;
  sgb_pkg::prods_t      hprod, vprod;
  logic                 pv_adv, v_free, v_emit, v_done, m_free, o_free;
  logic [DB-1:0]        hval;
  logic                 ge_r;
  logic [RB-1:0]        rad;

  assign hm1         = sgb_pkg::eff_hm1(cfg);
  assign rad         = RB'(cfg.radius);

  always_comb begin
    for (int k = 0; k < WD; k++) lane_taps[k] = sgb_pkg::lane_tap(LB'(k), cfg);
  end

  assign o_free  = !o_valid_r || !out_stall;
  assign m_free  = !m_valid_r || o_free;
  assign v_emit  = v_valid_r && v_has_y_r && m_free;
  assign v_done  = v_valid_r && (!v_has_y_r || (v_emit && v_y_r == v_yend_r));
  assign v_free  = !v_valid_r || v_done;
  assign pv_adv  = p_valid_r && v_free;
  assign q_pop   = !q_empty && (!p_valid_r || pv_adv);

  // line store: one bank per row modulo the window depth
  for (genvar b = 0; b < WD; b++) begin : g_bank
    assign bank_we[b]  = v_valid_r && (v_rmod_r == 3'(b));
    assign hit_head[b] = bank_we[b] && (v_x_r == q_head.x);
    assign hit_p[b]    = bank_we[b] && (v_x_r == p_x_r);
    sgb_ram #(.WIDTH(DB), .DEPTH(sgb_pkg::MAX_WIDTH)) u_line (
      .clk  (clk),
      .we   (bank_we[b]),
      .waddr(v_x_r),
      .wdata(v_hval_r),
      .re   (q_pop),
      .raddr(q_head.x),
      .rdata(ram_q[b])
    );
  end

  // writes that land after the read was issued are patched in
  always_comb begin
    p_patch_nxt = p_patch_r;
    p_pval_nxt  = p_pval_r;
    for (int b = 0; b < WD; b++) begin
      if (q_pop) begin
        p_patch_nxt[b] = hit_head[b];
        p_pval_nxt[b]  = v_hval_r;
      end else if (hit_p[b]) begin
        p_patch_nxt[b] = 1'b1;
        p_pval_nxt[b]  = v_hval_r;
      end
      if (hit_p[b]) col_in[b] = v_hval_r;
      else if (p_patch_r[b]) col_in[b] = p_pval_r[b];
      else col_in[b] = ram_q[b];
    end
  end

  always_comb begin
    for (int k = 0; k < WD; k++)
      hprod[k] = q_head.hop[k] * lane_taps[k];
  end

  assign hval = (cfg.radius == '0) ? p_center_r
                                   : sgb_pkg::finish(sgb_pkg::sum_prods(p_prod_r));
  assign ge_r = (p_row_r >= rad);

  // vertical operands for the row under way, clamped at top and bottom
  always_comb begin
    logic signed [RB+1:0] ys;
    logic signed [RB+1:0] yc;
    logic [RB-1:0]        yy, diff;
    logic [3:0]           bk;
    logic [LB-1:0]        lane_d;
    for (int k = 0; k < WD; k++) begin
      ys = $signed({2'b00, v_y_r}) + $signed((RB+2)'(k)) -
           $signed((RB+2)'(sgb_pkg::MAX_RADIUS));
      if (ys < 0) yc = '0;
      else if (ys > $signed({2'b00, hm1})) yc = $signed({2'b00, hm1});
      else yc = ys;
      yy     = yc[RB-1:0];
      diff   = v_row_r - yy;
      bk     = {1'b0, v_rmod_r} + 4'd7 - {1'b0, diff[2:0]};
      if (bk >= 4'd7) bk = bk - 4'd7;
      lane_d = (k >= sgb_pkg::MAX_RADIUS) ? LB'(k - sgb_pkg::MAX_RADIUS)
                                          : LB'(sgb_pkg::MAX_RADIUS - k);
      if (lane_d > LB'(cfg.radius)) vop[k] = '0;
      else if (yy == v_row_r) vop[k] = v_hval_r;
      else vop[k] = v_col_r[bk[2:0]];
      vprod[k] = vop[k] * lane_taps[k];
    end
  end

  always_comb begin
    p_valid_nxt = p_valid_r;
    v_valid_nxt = v_valid_r;
    m_valid_nxt = m_valid_r;
    o_valid_nxt = o_valid_r;
    v_y_nxt     = v_y_r;
    if (q_pop) p_valid_nxt = 1'b1;
    else if (pv_adv) p_valid_nxt = 1'b0;
    if (pv_adv) v_valid_nxt = 1'b1;
    else if (v_done) v_valid_nxt = 1'b0;
    if (pv_adv) v_y_nxt = ge_r ? p_row_r - rad : '0;
    else if (v_emit && !v_done) v_y_nxt = v_y_r + RB'(1);
    if (v_emit) m_valid_nxt = 1'b1;
    else if (o_free) m_valid_nxt = 1'b0;
    if (m_valid_r && o_free) o_valid_nxt = 1'b1;
    else if (!out_stall) o_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    p_patch_r <= p_patch_nxt;
    p_pval_r  <= p_pval_nxt;
    v_y_r     <= v_y_nxt;
    if (q_pop) begin
      p_prod_r     <= hprod;
      p_center_r   <= q_head.hop[sgb_pkg::MAX_RADIUS];
      p_x_r        <= q_head.x;
      p_row_r      <= q_head.row;
      p_rmod_r     <= q_head.rmod;
      p_last_row_r <= q_head.last_row;
      p_last_job_r <= q_head.last_job;
    end
    if (pv_adv) begin
      v_hval_r     <= hval;
      v_col_r      <= col_in;
      v_x_r        <= p_x_r;
      v_row_r      <= p_row_r;
      v_rmod_r     <= p_rmod_r;
      v_last_job_r <= p_last_job_r;
      v_has_y_r    <= p_last_row_r || ge_r;
      v_yend_r     <= p_last_row_r ? p_row_r : p_row_r - rad;
    end
    if (v_emit) begin
      m_prod_r   <= vprod;
      m_center_r <= vop[sgb_pkg::MAX_RADIUS];
      m_x_r      <= v_x_r;
      m_y_r      <= v_y_r;
      m_last_r   <= v_last_job_r && (v_y_r == v_yend_r);
    end
    if (m_valid_r && o_free) begin
      o_value_r <= (cfg.radius == '0) ? m_center_r
                                      : sgb_pkg::finish(sgb_pkg::sum_prods(m_prod_r));
      o_x_r     <= m_x_r;
      o_y_r     <= m_y_r;
      o_last_r  <= m_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      v_valid_r <= 1'b0;
      m_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      p_valid_r <= p_valid_nxt;
      v_valid_r <= v_valid_nxt;
      m_valid_r <= m_valid_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  assign out_valid       = o_valid_r;
  assign out_value       = o_value_r;
  assign out_x           = o_x_r;
  assign out_y           = o_y_r;
  assign out_last_of_run = o_last_r;

  a_bank_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(bank_we)) else $error("more than one line bank written");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("job popped from empty queue");

  a_m_hold: assert property (@(posedge clk) disable iff (!rst_n)
    m_valid_r && !o_free |=> m_valid_r && $stable(m_y_r) && $stable(m_x_r))
    else $error("vertical stage lost a held item");

  a_row_walk: assert property (@(posedge clk) disable iff (!rst_n)
    v_emit && !v_done |=> v_valid_r && (v_y_r == $past(v_y_r) + 16'd1))
    else $error("output row walk skipped");

endmodule
`default_nettype wire

/* sv/separable_gaussian_blur_unit.sv */
// Top level of the separable blur unit: configuration registers, front end, queue, back end.
//
// Usage:
//  - Samples enter on in_valid/in_stall/in_sample in raster order; an item is
//    taken on a rising edge with in_valid high and in_stall low.
//  - Results leave on out_valid/out_stall with value, column, row and a flag
//    marking the last result caused by one input item.
//  - Registers are written on cfg_valid/cfg_ready (always ready) with cfg_index
//    and cfg_data; the user must write them only while the unit is idle (not enforced).
//    Writing width, height or radius restarts the frame; tap writes apply at once.
//  - Throughput: one sample per cycle inside a row while the job queue has room. The
//    front end issues one horizontal job per cycle while the queue has room, so a
//    row-end sample holds in_stall until its jobs are issued. The vertical MAC makes
//    one result per cycle unless out_stall holds it; in the last row each job
//    walks up to r+1 rows, which backs up the job queue and then the input.
//  - Path: queue, horizontal MAC and store read, row walk, vertical MAC, output register.
//  - Reset clears counters and all valid flags; registers return to a 640x480
//    frame, radius 3 and the default taps. The line store needs no clearing.
//  - When out_stall is high the output register holds; the pipe fills up, the
//    queue backs up, then in_stall rises.
`default_nettype none
module separable_gaussian_blur_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [sgb_pkg::DATA_BITS-1:0]       in_sample,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [sgb_pkg::DATA_BITS-1:0]            out_value,
  output logic [sgb_pkg::COL_BITS-1:0]             out_x,
  output logic [sgb_pkg::ROW_BITS-1:0]             out_y,
  output logic                                     out_last_of_run,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [sgb_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [sgb_pkg::CFG_DAT_BITS-1:0]    cfg_data
);

  sgb_pkg::cfg_t  cfg_r, cfg_nxt;
  logic           cfg_wr, restart;
  logic           q_push, q_full, q_pop, q_empty;
  sgb_pkg::hjob_t q_job, q_head;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign restart   = cfg_wr && (cfg_index == sgb_pkg::REG_WIDTH ||
                                cfg_index == sgb_pkg::REG_HEIGHT ||
                                cfg_index == sgb_pkg::REG_RADIUS);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (cfg_index)
        sgb_pkg::REG_WIDTH:  cfg_nxt.width   = cfg_data[sgb_pkg::WREG_BITS-1:0];
        sgb_pkg::REG_HEIGHT: cfg_nxt.height  = cfg_data[sgb_pkg::ROW_BITS-1:0];
        sgb_pkg::REG_RADIUS: cfg_nxt.radius  = cfg_data[sgb_pkg::RAD_BITS-1:0];
        sgb_pkg::REG_TAP0:   cfg_nxt.taps[0] = cfg_data[sgb_pkg::TAP_BITS-1:0];
        sgb_pkg::REG_TAP1:   cfg_nxt.taps[1] = cfg_data[sgb_pkg::TAP_BITS-1:0];
        sgb_pkg::REG_TAP2:   cfg_nxt.taps[2] = cfg_data[sgb_pkg::TAP_BITS-1:0];
        sgb_pkg::REG_TAP3:   cfg_nxt.taps[3] = cfg_data[sgb_pkg::TAP_BITS-1:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width   <= 11'd640;
      cfg_r.height  <= 16'd480;
      cfg_r.radius  <= 2'd3;
      cfg_r.taps[0] <= 16'd26153;
      cfg_r.taps[1] <= 16'd15862;
      cfg_r.taps[2] <= 16'd3539;
      cfg_r.taps[3] <= 16'd290;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sgb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .restart  (restart),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_sample(in_sample),
    .q_push   (q_push),
    .q_job    (q_job),
    .q_full   (q_full)
  );

  sgb_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_job(q_job),
    .full    (q_full),
    .pop     (q_pop),
    .head    (q_head),
    .empty   (q_empty)
  );

  sgb_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value      (out_value),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_last_of_run(out_last_of_run)
  );

endmodule
`default_nettype wire
